// ===== src/urlh_pkg.sv =====
// Shared types, character codes and character-class helpers for the URL host extractor.
// Used by urlh_scan, urlh_host and url_host_extractor; depends on nothing else.
package urlh_pkg;

    // Default buffer limit and the fixed width of the reported offsets.
    localparam int URLH_MAX_URL_LEN = 4096;
    localparam int URLH_OUT_W       = 13;

    // Character codes that steer the scan.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Scan phase of the current URL.
    typedef enum logic [2:0] {
        PH_LEAD_WS,      // skipping leading whitespace
        PH_FIRST_SLASH,  // first visible byte was a slash
        PH_SCAN,         // inside the authority part
        PH_COLON,        // just passed the scheme colon
        PH_COLON_SLASH,  // scheme colon followed by one slash
        PH_DONE          // end of the host found
    } phase_t;

    // Bracketed IPv6 tracking from the host start.
    typedef enum logic [1:0] {
        BRK_FIRST,   // next byte is the first host byte
        BRK_INSIDE,  // inside a bracketed literal
        BRK_DONE     // port colons now count
    } brk_t;

    // Flags captured with the end-of-URL snapshot.
    typedef struct packed {
        logic ovf;      // URL was longer than the buffer
        logic no_host;  // no host byte could ever start
        logic fnd_v;    // a non-dot host byte was seen
        logic edot;     // byte before the host end is a dot
    } urlh_flags_t;

    // One result word.
    typedef struct packed {
        logic [URLH_OUT_W-1:0] host_start;
        logic [URLH_OUT_W-1:0] host_length;
        logic                  is_null;
        logic                  overflow;
    } urlh_result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic is_slash(input logic [7:0] c);
        return c inside {CH_SLASH, CH_BSLASH};
    endfunction

    function automatic logic is_netloc_end(input logic [7:0] c);
        return c inside {CH_HASH, CH_QUEST, CH_SLASH, CH_BSLASH};
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c inside {CH_LBRACK, CH_RBRACK};
    endfunction

endpackage

// ===== src/url_host_extractor.sv =====
// URL host extractor: one URL byte per input word, one result word per URL.
// The result passes from the input register through the snapshot register to the output register behind m_tvalid.
// Throughput: one input word every cycle, set by the combinational byte scan update.
// Only the word that ends a URL waits when the result stages are full.
// Reset (rst_n low) clears all control state at once; no clearing pass is needed.
module url_host_extractor
    import urlh_pkg::*;
#(
    parameter int   MAX_URL_LEN = URLH_MAX_URL_LEN,
    localparam int  POS_W       = $clog2(MAX_URL_LEN + 1)
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last byte of the URL
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] host_start, [25:13] host_length, [31:26] zero
    output logic [1:0]  m_tuser    // [0] is_null, [1] overflow
);

    // Input register.
    logic              in_v_reg, in_v_next;
    logic [7:0]        in_ch_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // Snapshot register.
    logic              snap_v_reg, snap_v_next;
    urlh_flags_t       snap_flags_reg;
    logic [POS_W-1:0]  snap_e_reg;
    logic [POS_W-1:0]  snap_elnd_reg;
    logic [POS_W-1:0]  snap_fnd_reg;

    // Output register.
    logic              out_v_reg, out_v_next;
    urlh_result_t      out_res_reg;

    urlh_flags_t       snap_flags;
    logic [POS_W-1:0]  snap_e;
    logic [POS_W-1:0]  snap_elnd;
    logic [POS_W-1:0]  snap_fnd;
    urlh_result_t      host_res;

    logic              out_free;
    logic              snap_free;
    logic              proc_en;
    logic              in_take;
    logic              snap_move;

    // Flow control: a word ending a URL needs a free snapshot slot.
    assign out_free  = !out_v_reg || m_tready;
    assign snap_free = !snap_v_reg || out_free;
    assign proc_en   = in_v_reg && (!in_last_reg || snap_free);
    assign s_tready  = !in_v_reg || proc_en;
    assign in_take   = s_tvalid && s_tready;
    assign snap_move = snap_v_reg && out_free;

    always_comb
    begin
        in_v_next   = in_take ? 1'b1 : (proc_en ? 1'b0 : in_v_reg);
        snap_v_next = (proc_en && in_last_reg) ? 1'b1 : (snap_move ? 1'b0 : snap_v_reg);
        out_v_next  = snap_move ? 1'b1 : (m_tready ? 1'b0 : out_v_reg);
    end

    urlh_scan #(
        .MAX_URL_LEN (MAX_URL_LEN)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc_en    (proc_en),
        .ch         (in_ch_reg),
        .has_byte   (in_has_reg),
        .last       (in_last_reg),
        .snap_flags (snap_flags),
        .snap_e     (snap_e),
        .snap_elnd  (snap_elnd),
        .snap_fnd   (snap_fnd)
    );

    urlh_host #(
        .MAX_URL_LEN (MAX_URL_LEN)
    ) u_host (
        .flags (snap_flags_reg),
        .e     (snap_e_reg),
        .elnd  (snap_elnd_reg),
        .fnd   (snap_fnd_reg),
        .res   (host_res)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            snap_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            in_v_reg   <= in_v_next;
            snap_v_reg <= snap_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
        if (proc_en && in_last_reg)
        begin
            snap_flags_reg <= snap_flags;
            snap_e_reg     <= snap_e;
            snap_elnd_reg  <= snap_elnd;
            snap_fnd_reg   <= snap_fnd;
        end
        if (snap_move)
        begin
            out_res_reg <= host_res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_res_reg.host_length, out_res_reg.host_start};
    assign m_tuser  = {out_res_reg.overflow, out_res_reg.is_null};

    // A waiting snapshot is never dropped while the output stage is blocked.
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_v_reg && !out_free) |=> snap_v_reg)
        else $error("snapshot lost while output stalled");

    // Words inside a URL never wait on the result side.
    a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !in_last_reg) |-> s_tready)
        else $error("mid-URL word stalled");

    // Overflow results carry no span and no null flag.
    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata == 32'd0) && !m_tuser[0]))
        else $error("overflow result with nonzero fields");

    // Null results carry no span.
    a_null_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata == 32'd0) && !m_tuser[1]))
        else $error("null result with nonzero fields");

    // A reported host is never empty.
    a_host_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0] && !m_tuser[1]) |-> (m_tdata[25:13] != 13'd0))
        else $error("non-null host with zero length");

endmodule

// ===== src/urlh_scan.sv =====
// Per-byte scan of a URL: phase machine, host boundary and dot tracking.
// Produces the end-of-URL snapshot; depends on urlh_pkg.
module urlh_scan
    import urlh_pkg::*;
#(
    parameter int   MAX_URL_LEN = URLH_MAX_URL_LEN,
    localparam int  POS_W       = $clog2(MAX_URL_LEN + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              proc_en,     // the registered word is consumed this cycle
    input  logic [7:0]        ch,
    input  logic              has_byte,
    input  logic              last,
    output urlh_flags_t       snap_flags,
    output logic [POS_W-1:0]  snap_e,      // host end before dot trimming
    output logic [POS_W-1:0]  snap_elnd,   // last non-dot before the byte at snap_e - 1
    output logic [POS_W-1:0]  snap_fnd     // first non-dot host byte
);

    // Control state.
    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    phase_t           phase_reg, phase_next, phase_upd;
    logic             armed_reg, armed_next, armed_upd;
    brk_t             brk_reg, brk_next, brk_b, brk_upd;
    logic             cut_v_reg, cut_v_next, cut_v_b, cut_v_upd;
    logic             run_dot_reg, run_dot_next, run_dot_b, run_dot_upd;
    logic             fnd_v_reg, fnd_v_next, fnd_v_b, fnd_v_upd;

    // Position state, loaded without reset.
    logic [POS_W-1:0] end_reg, end_upd;
    logic [POS_W-1:0] cut_reg, cut_upd;
    logic             cut_dot_reg, cut_dot_upd;
    logic [POS_W-1:0] cut_lnd_reg, cut_lnd_upd;
    logic [POS_W-1:0] run_lnd_reg, run_lnd_upd;
    logic [POS_W-1:0] ns_end_reg, ns_end_upd;
    logic             ns_dot_reg, ns_dot_upd;
    logic [POS_W-1:0] ns_lnd_reg, ns_lnd_upd;
    logic [POS_W-1:0] fnd_reg, fnd_upd;

    logic             byte_ok;
    logic [POS_W-1:0] pos_inc;
    logic             scan_it;
    logic             clr_base;
    logic             clr_at;
    logic             track;
    logic             ch_dot;

    assign byte_ok = has_byte && (pos_reg != POS_W'(MAX_URL_LEN));
    assign pos_inc = pos_reg + POS_W'(1);
    assign ch_dot  = (ch == CH_DOT);

    // Phase update for one byte.
    always_comb
    begin
        phase_upd = phase_reg;
        armed_upd = armed_reg;
        end_upd   = end_reg;
        scan_it   = 1'b0;
        clr_base  = 1'b0;
        clr_at    = 1'b0;
        track     = 1'b0;
        if (byte_ok)
        begin
            case (phase_reg)
                PH_LEAD_WS:
                begin
                    if (!is_ws(ch))
                    begin
                        if (is_slash(ch))
                        begin
                            phase_upd = PH_FIRST_SLASH;
                        end
                        else
                        begin
                            clr_base = 1'b1;
                            scan_it  = 1'b1;
                        end
                    end
                end
                PH_FIRST_SLASH:
                begin
                    // A leading double slash skips scheme detection.
                    if (is_slash(ch))
                    begin
                        phase_upd = PH_SCAN;
                        armed_upd = 1'b0;
                        clr_base  = 1'b1;
                    end
                    else
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                PH_SCAN:
                begin
                    scan_it = 1'b1;
                end
                PH_COLON:
                begin
                    if (is_slash(ch))
                    begin
                        phase_upd = PH_COLON_SLASH;
                        end_upd   = pos_reg;
                    end
                    else
                    begin
                        scan_it = 1'b1;
                    end
                end
                PH_COLON_SLASH:
                begin
                    // Second slash completes the scheme separator; otherwise the
                    // first slash already ended the host.
                    if (is_slash(ch))
                    begin
                        phase_upd = PH_SCAN;
                        clr_base  = 1'b1;
                    end
                    else
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase

            // Authority byte handling.
            if (scan_it)
            begin
                phase_upd = PH_SCAN;
                if (is_netloc_end(ch))
                begin
                    phase_upd = PH_DONE;
                    end_upd   = pos_reg;
                end
                else if (armed_reg && (ch == CH_COLON))
                begin
                    armed_upd = 1'b0;
                    phase_upd = PH_COLON;
                    track     = 1'b1;
                end
                else if (ch == CH_AT)
                begin
                    clr_at = 1'b1;
                end
                else
                begin
                    track = 1'b1;
                end
            end
        end
    end

    // Host tracking: brackets, port colon, dots.
    always_comb
    begin
        brk_b       = (clr_base || clr_at) ? BRK_FIRST : brk_reg;
        cut_v_b     = (clr_base || clr_at) ? 1'b0 : cut_v_reg;
        run_dot_b   = (clr_base || clr_at) ? 1'b0 : run_dot_reg;
        fnd_v_b     = (clr_base || clr_at) ? 1'b0 : fnd_v_reg;

        brk_upd     = brk_b;
        cut_v_upd   = cut_v_b;
        cut_upd     = cut_reg;
        cut_dot_upd = cut_dot_reg;
        cut_lnd_upd = cut_lnd_reg;
        run_dot_upd = run_dot_b;
        run_lnd_upd = run_lnd_reg;
        fnd_v_upd   = fnd_v_b;
        fnd_upd     = fnd_reg;

        if (track)
        begin
            case (brk_b)
                BRK_FIRST:
                begin
                    brk_upd = (ch == CH_LBRACK) ? BRK_INSIDE : BRK_DONE;
                end
                BRK_INSIDE:
                begin
                    if (is_bracket(ch))
                    begin
                        brk_upd = BRK_DONE;
                    end
                end
                default:
                begin
                    brk_upd = brk_b;
                end
            endcase

            // First port colon outside a bracketed literal cuts the host.
            if (!cut_v_b && (ch == CH_COLON) && (brk_b != BRK_INSIDE))
            begin
                cut_v_upd   = 1'b1;
                cut_upd     = pos_reg;
                cut_dot_upd = run_dot_b;
                cut_lnd_upd = run_lnd_reg;
            end

            if (ch_dot)
            begin
                run_dot_upd = 1'b1;
            end
            else
            begin
                run_dot_upd = 1'b0;
                run_lnd_upd = pos_reg;
            end

            if (!fnd_v_b && !ch_dot)
            begin
                fnd_v_upd = 1'b1;
                fnd_upd   = pos_reg;
            end
        end
    end

    // Trailing whitespace bound and byte count.
    always_comb
    begin
        ns_end_upd = ns_end_reg;
        ns_dot_upd = ns_dot_reg;
        ns_lnd_upd = ns_lnd_reg;
        if (byte_ok && !is_ws(ch))
        begin
            ns_end_upd = pos_inc;
            ns_dot_upd = ch_dot;
            ns_lnd_upd = ch_dot ? run_lnd_reg : pos_reg;
        end
        pos_upd = byte_ok ? pos_inc : pos_reg;
        ovf_upd = ovf_reg || (has_byte && !byte_ok);
    end

    // Next state: hold, advance, or return to the start of a URL after the last word.
    always_comb
    begin
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        brk_next     = brk_reg;
        cut_v_next   = cut_v_reg;
        run_dot_next = run_dot_reg;
        fnd_v_next   = fnd_v_reg;
        if (proc_en)
        begin
            if (last)
            begin
                pos_next     = '0;
                ovf_next     = 1'b0;
                phase_next   = PH_LEAD_WS;
                armed_next   = 1'b1;
                brk_next     = BRK_FIRST;
                cut_v_next   = 1'b0;
                run_dot_next = 1'b0;
                fnd_v_next   = 1'b0;
            end
            else
            begin
                pos_next     = pos_upd;
                ovf_next     = ovf_upd;
                phase_next   = phase_upd;
                armed_next   = armed_upd;
                brk_next     = brk_upd;
                cut_v_next   = cut_v_upd;
                run_dot_next = run_dot_upd;
                fnd_v_next   = fnd_v_upd;
            end
        end
    end

    // Snapshot outputs: pick the host end that applies and its dot context.
    always_comb
    begin
        snap_flags.ovf     = ovf_upd;
        snap_flags.no_host = (phase_upd == PH_LEAD_WS) || (phase_upd == PH_FIRST_SLASH);
        snap_flags.fnd_v   = fnd_v_upd;
        snap_fnd           = fnd_upd;
        if (cut_v_upd)
        begin
            snap_e          = cut_upd;
            snap_flags.edot = cut_dot_upd;
            snap_elnd       = cut_lnd_upd;
        end
        else if ((phase_upd == PH_DONE) || (phase_upd == PH_COLON_SLASH))
        begin
            snap_e          = end_upd;
            snap_flags.edot = run_dot_upd;
            snap_elnd       = run_lnd_upd;
        end
        else
        begin
            snap_e          = ns_end_upd;
            snap_flags.edot = ns_dot_upd;
            snap_elnd       = ns_lnd_upd;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            phase_reg   <= PH_LEAD_WS;
            armed_reg   <= 1'b1;
            brk_reg     <= BRK_FIRST;
            cut_v_reg   <= 1'b0;
            run_dot_reg <= 1'b0;
            fnd_v_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            brk_reg     <= brk_next;
            cut_v_reg   <= cut_v_next;
            run_dot_reg <= run_dot_next;
            fnd_v_reg   <= fnd_v_next;
        end
    end

    // Position registers; they are only read behind the valid flags above.
    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            end_reg     <= end_upd;
            cut_reg     <= cut_upd;
            cut_dot_reg <= cut_dot_upd;
            cut_lnd_reg <= cut_lnd_upd;
            run_lnd_reg <= run_lnd_upd;
            ns_end_reg  <= ns_end_upd;
            ns_dot_reg  <= ns_dot_upd;
            ns_lnd_reg  <= ns_lnd_upd;
            fnd_reg     <= fnd_upd;
        end
    end

endmodule

// ===== src/urlh_host.sv =====
// Final host span from the end-of-URL snapshot: dot trimming and null/overflow cases.
// Combinational; depends on urlh_pkg.
module urlh_host
    import urlh_pkg::*;
#(
    parameter int   MAX_URL_LEN = URLH_MAX_URL_LEN,
    localparam int  POS_W       = $clog2(MAX_URL_LEN + 1)
)(
    input  urlh_flags_t       flags,
    input  logic [POS_W-1:0]  e,
    input  logic [POS_W-1:0]  elnd,
    input  logic [POS_W-1:0]  fnd,
    output urlh_result_t      res
);

    logic             start_ok;
    logic [POS_W-1:0] e_fin;
    logic [POS_W-1:0] len;

    // Leading dots are gone once the start sits on the first non-dot byte;
    // a trailing run of dots keeps only its first dot.
    assign start_ok = flags.fnd_v && (fnd < e);
    assign e_fin    = flags.edot ? (elnd + POS_W'(2)) : e;
    assign len      = e_fin - fnd;

    // Result word with the special cases forced to zero fields.
    always_comb
    begin
        res = '0;
        if (flags.ovf)
        begin
            res.overflow = 1'b1;
        end
        else if (flags.no_host || !start_ok)
        begin
            res.is_null = 1'b1;
        end
        else
        begin
            res.host_start  = URLH_OUT_W'(fnd);
            res.host_length = URLH_OUT_W'(len);
        end
    end

endmodule
